// File: src/rna_pkg.sv
// ----------------------------------------------------------------------------
// rna_pkg: shared types and constants for the rational number ALU
// Operation and status codes, datapath commands, controller states.
// ----------------------------------------------------------------------------
package rna_pkg;

	localparam int WORD_BITS = 32;
	localparam int XW        = 64;

	localparam logic [2:0] OP_NORM = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;
	localparam logic [2:0] OP_CMP  = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	// 2^(WORD_BITS-1) at double width
	localparam logic [XW-1:0] LIM = {{(XW-1){1'b0}}, 1'b1} << (WORD_BITS - 1);

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_WORK_A,
		CMD_WORK_B,
		CMD_STORE_A,
		CMD_STORE_B,
		CMD_GCD_WORK,
		CMD_GCD_DEN,
		CMD_GCD_STEP,
		CMD_DIV_N,
		CMD_DIV_D,
		CMD_DIV_BD,
		CMD_DIV_AD,
		CMD_DIV_STEP,
		CMD_SET_N,
		CMD_SET_D,
		CMD_SET_FA,
		CMD_SET_FB,
		CMD_MUL_PN,
		CMD_MUL_PD,
		CMD_MUL_QN,
		CMD_MUL_QD,
		CMD_MUL_L,
		CMD_MUL_TA,
		CMD_MUL_TB,
		CMD_SUM,
		CMD_RES_WORK,
		CMD_RES_ZERO,
		CMD_RES_ERR,
		CMD_RES_CMP
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       den_err;
		logic       bn_zero;
		logic       gcd_done;
		logic       div_done;
	} dp_stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_RGCD_INIT,
		S_RGCD,
		S_RDIVN_INIT,
		S_RDIVN,
		S_RSETN,
		S_RDIVD_INIT,
		S_RDIVD,
		S_RSETD,
		S_RET,
		S_LOADB,
		S_OPSEL,
		S_MULD,
		S_MULQD,
		S_LGCD,
		S_LDIVA_INIT,
		S_LDIVA,
		S_LSETA,
		S_LDIVB_INIT,
		S_LDIVB,
		S_LSETB,
		S_MUL_L,
		S_MUL_TA,
		S_MUL_TB,
		S_SUM,
		S_FIN_WORK,
		S_FIN_ZERO,
		S_FIN_ERR,
		S_FIN_CMP
	} state_t;

	typedef enum logic [1:0] {
		PH_A,
		PH_B,
		PH_R
	} phase_t;

	// sign-extend the low WORD_BITS bits to 32
	function automatic logic signed [31:0] sx_word(input logic [31:0] v);
		logic signed [WORD_BITS-1:0] t;
		t = v[WORD_BITS-1:0];
		return 32'(t);
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

endpackage

// File: src/rna_ctrl.sv
// ----------------------------------------------------------------------------
// rna_ctrl: sequencing controller
// Walks each valid request through operand reduction, the operation and,
// where needed, the final reduction; owns the request and result handshakes.
// ----------------------------------------------------------------------------
module rna_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  rna_pkg::dp_stat_t stat,
	output rna_pkg::dp_cmd_t  cmd
);
	import rna_pkg::*;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic   out_valid_q;
	logic   res_free;
	logic   res_load;

	assign res_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_A;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.op > OP_CMP) begin
					state_d = S_FIN_ZERO;
				end else if (stat.den_err) begin
					state_d = S_FIN_ERR;
				end else begin
					state_d = S_RGCD_INIT;
					phase_d = PH_A;
				end
			end
			S_RGCD_INIT:  state_d = S_RGCD;
			S_RGCD:       if (stat.gcd_done) state_d = S_RDIVN_INIT;
			S_RDIVN_INIT: state_d = S_RDIVN;
			S_RDIVN:      if (stat.div_done) state_d = S_RSETN;
			S_RSETN:      state_d = S_RDIVD_INIT;
			S_RDIVD_INIT: state_d = S_RDIVD;
			S_RDIVD:      if (stat.div_done) state_d = S_RSETD;
			S_RSETD:      state_d = S_RET;
			S_RET: begin
				case (phase_q)
					PH_A:    state_d = (stat.op == OP_NORM) ? S_FIN_WORK : S_LOADB;
					PH_B:    state_d = S_OPSEL;
					default: state_d = S_FIN_WORK;
				endcase
			end
			S_LOADB: begin
				state_d = S_RGCD_INIT;
				phase_d = PH_B;
			end
			S_OPSEL: begin
				if (stat.op inside {OP_ADD, OP_SUB, OP_CMP}) begin
					state_d = S_LGCD;
				end else if (stat.op == OP_MUL) begin
					state_d = S_MULD;
				end else if (stat.bn_zero) begin
					state_d = S_FIN_ERR;
				end else begin
					state_d = S_MULQD;
				end
			end
			S_MULD, S_MULQD: begin
				state_d = S_RGCD_INIT;
				phase_d = PH_R;
			end
			S_LGCD:       if (stat.gcd_done) state_d = S_LDIVA_INIT;
			S_LDIVA_INIT: state_d = S_LDIVA;
			S_LDIVA:      if (stat.div_done) state_d = S_LSETA;
			S_LSETA:      state_d = S_LDIVB_INIT;
			S_LDIVB_INIT: state_d = S_LDIVB;
			S_LDIVB:      if (stat.div_done) state_d = S_LSETB;
			S_LSETB:      state_d = S_MUL_L;
			S_MUL_L:      state_d = S_MUL_TA;
			S_MUL_TA:     state_d = S_MUL_TB;
			S_MUL_TB:     state_d = S_SUM;
			S_SUM: begin
				if (stat.op == OP_CMP) begin
					state_d = S_FIN_CMP;
				end else begin
					state_d = S_RGCD_INIT;
					phase_d = PH_R;
				end
			end
			S_FIN_WORK, S_FIN_ZERO, S_FIN_ERR, S_FIN_CMP: begin
				if (res_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = CMD_NONE;
		res_load = 1'b0;
		case (state_q)
			S_IDLE:       if (in_valid) cmd = CMD_LOAD;
			S_CHECK: begin
				if (stat.op <= OP_CMP && !stat.den_err) cmd = CMD_WORK_A;
			end
			S_RGCD_INIT:  cmd = CMD_GCD_WORK;
			S_RGCD:       cmd = CMD_GCD_STEP;
			S_RDIVN_INIT: cmd = CMD_DIV_N;
			S_RDIVN:      cmd = CMD_DIV_STEP;
			S_RSETN:      cmd = CMD_SET_N;
			S_RDIVD_INIT: cmd = CMD_DIV_D;
			S_RDIVD:      cmd = CMD_DIV_STEP;
			S_RSETD:      cmd = CMD_SET_D;
			S_RET: begin
				case (phase_q)
					PH_A:    cmd = CMD_STORE_A;
					PH_B:    cmd = CMD_STORE_B;
					default: cmd = CMD_NONE;
				endcase
			end
			S_LOADB:      cmd = CMD_WORK_B;
			S_OPSEL: begin
				if (stat.op inside {OP_ADD, OP_SUB, OP_CMP}) begin
					cmd = CMD_GCD_DEN;
				end else if (stat.op == OP_MUL) begin
					cmd = CMD_MUL_PN;
				end else if (!stat.bn_zero) begin
					cmd = CMD_MUL_QN;
				end
			end
			S_MULD:       cmd = CMD_MUL_PD;
			S_MULQD:      cmd = CMD_MUL_QD;
			S_LGCD:       cmd = CMD_GCD_STEP;
			S_LDIVA_INIT: cmd = CMD_DIV_BD;
			S_LDIVA:      cmd = CMD_DIV_STEP;
			S_LSETA:      cmd = CMD_SET_FA;
			S_LDIVB_INIT: cmd = CMD_DIV_AD;
			S_LDIVB:      cmd = CMD_DIV_STEP;
			S_LSETB:      cmd = CMD_SET_FB;
			S_MUL_L:      cmd = CMD_MUL_L;
			S_MUL_TA:     cmd = CMD_MUL_TA;
			S_MUL_TB:     cmd = CMD_MUL_TB;
			S_SUM:        cmd = CMD_SUM;
			S_FIN_WORK: begin
				res_load = res_free;
				if (res_free) cmd = CMD_RES_WORK;
			end
			S_FIN_ZERO: begin
				res_load = res_free;
				if (res_free) cmd = CMD_RES_ZERO;
			end
			S_FIN_ERR: begin
				res_load = res_free;
				if (res_free) cmd = CMD_RES_ERR;
			end
			S_FIN_CMP: begin
				res_load = res_free;
				if (res_free) cmd = CMD_RES_CMP;
			end
			default: cmd = CMD_NONE;
		endcase
	end

endmodule

// File: src/rna_dp.sv
// ----------------------------------------------------------------------------
// rna_dp: datapath
// Operand registers, binary gcd engine, restoring divider, one 32x32
// multiplier, sign-magnitude adder and the result register.
// ----------------------------------------------------------------------------
module rna_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  rna_pkg::dp_cmd_t    cmd,
	output rna_pkg::dp_stat_t   stat,
	input  logic [2:0]          operation,
	input  logic signed [31:0]  a_num,
	input  logic signed [31:0]  a_den,
	input  logic signed [31:0]  b_num,
	input  logic signed [31:0]  b_den,
	output logic signed [31:0]  res_num,
	output logic [30:0]         res_den,
	output logic                is_less,
	output logic                is_equal,
	output logic                is_greater,
	output logic [1:0]          status
);
	import rna_pkg::*;

	// operands, sign and magnitude
	logic [2:0]    op_q;
	logic          an_s_q, ad_s_q, bn_s_q, bd_s_q;
	logic [31:0]   an_m_q, ad_m_q, bn_m_q, bd_m_q;
	logic [31:0]   fa_q, fb_q;

	// value under reduction, sign folded into the numerator
	logic          ws_q;
	logic [XW-1:0] wn_q, wd_q;
	logic          ts_q;
	logic [XW-1:0] tm_q;

	// gcd engine
	logic [XW-1:0] gx_q, gy_q, g_q;
	logic [5:0]    gk_q;
	logic          gcd_done;

	// divider
	logic [XW-1:0] rem_q, quo_q;
	logic [6:0]    cnt_q;
	logic [XW:0]   div_sh;
	logic          div_ge;

	// multiplier
	logic [31:0]   mul_a, mul_b;
	logic [XW-1:0] prod;

	logic          sub_sel;
	logic          ovf;
	logic [31:0]   wn_lo;

	logic signed [31:0] res_num_q;
	logic [30:0]        res_den_q;
	logic               lt_q, eq_q, gt_q;
	logic [1:0]         st_q;

	assign gcd_done = (gx_q == '0) || (gy_q == '0);
	assign div_sh   = {rem_q, quo_q[XW-1]};
	assign div_ge   = div_sh >= {1'b0, g_q};
	assign sub_sel  = (op_q != OP_ADD);

	assign stat.op       = op_q;
	assign stat.den_err  = (ad_m_q == '0) || (op_q != OP_NORM && bd_m_q == '0);
	assign stat.bn_zero  = (bn_m_q == '0);
	assign stat.gcd_done = gcd_done;
	assign stat.div_done = (cnt_q == '0);

	always_comb begin
		case (cmd)
			CMD_MUL_PN: begin mul_a = an_m_q; mul_b = bn_m_q; end
			CMD_MUL_PD: begin mul_a = ad_m_q; mul_b = bd_m_q; end
			CMD_MUL_QN: begin mul_a = an_m_q; mul_b = bd_m_q; end
			CMD_MUL_QD: begin mul_a = ad_m_q; mul_b = bn_m_q; end
			CMD_MUL_L:  begin mul_a = ad_m_q; mul_b = fa_q;   end
			CMD_MUL_TA: begin mul_a = an_m_q; mul_b = fa_q;   end
			CMD_MUL_TB: begin mul_a = bn_m_q; mul_b = fb_q;   end
			default:    begin mul_a = '0;     mul_b = '0;     end
		endcase
	end

	assign prod = XW'(mul_a) * XW'(mul_b);

	assign ovf = (ws_q ? (wn_q > LIM) : (wn_q >= LIM)) || (wd_q >= LIM);
	assign wn_lo = wn_q[31:0];

	// operand and work registers
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				op_q   <= operation;
				an_s_q <= sx_word(a_num) < 0;
				ad_s_q <= sx_word(a_den) < 0;
				bn_s_q <= sx_word(b_num) < 0;
				bd_s_q <= sx_word(b_den) < 0;
				an_m_q <= mag32(sx_word(a_num));
				ad_m_q <= mag32(sx_word(a_den));
				bn_m_q <= mag32(sx_word(b_num));
				bd_m_q <= mag32(sx_word(b_den));
			end
			CMD_WORK_A: begin
				ws_q <= an_s_q ^ ad_s_q;
				wn_q <= XW'(an_m_q);
				wd_q <= XW'(ad_m_q);
			end
			CMD_WORK_B: begin
				ws_q <= bn_s_q ^ bd_s_q;
				wn_q <= XW'(bn_m_q);
				wd_q <= XW'(bd_m_q);
			end
			CMD_STORE_A: begin
				an_s_q <= ws_q;
				an_m_q <= wn_q[31:0];
				ad_m_q <= wd_q[31:0];
			end
			CMD_STORE_B: begin
				bn_s_q <= ws_q;
				bn_m_q <= wn_q[31:0];
				bd_m_q <= wd_q[31:0];
			end
			CMD_SET_N:  wn_q <= quo_q;
			CMD_SET_D:  wd_q <= quo_q;
			CMD_SET_FA: fa_q <= quo_q[31:0];
			CMD_SET_FB: fb_q <= quo_q[31:0];
			CMD_MUL_PN, CMD_MUL_QN: begin
				ws_q <= an_s_q ^ bn_s_q;
				wn_q <= prod;
			end
			CMD_MUL_PD, CMD_MUL_QD, CMD_MUL_L: wd_q <= prod;
			CMD_MUL_TA: begin
				ws_q <= an_s_q;
				wn_q <= prod;
			end
			CMD_MUL_TB: begin
				ts_q <= bn_s_q ^ sub_sel;
				tm_q <= prod;
			end
			CMD_SUM: begin
				if (ws_q == ts_q) begin
					wn_q <= wn_q + tm_q;
				end else if (wn_q >= tm_q) begin
					wn_q <= wn_q - tm_q;
					ws_q <= ws_q && (wn_q != tm_q);
				end else begin
					wn_q <= tm_q - wn_q;
					ws_q <= ts_q;
				end
			end
			default: ;
		endcase
	end

	// gcd engine, one binary step per cycle
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_GCD_WORK: begin
				gx_q <= wn_q;
				gy_q <= wd_q;
				gk_q <= '0;
			end
			CMD_GCD_DEN: begin
				gx_q <= XW'(ad_m_q);
				gy_q <= XW'(bd_m_q);
				gk_q <= '0;
			end
			CMD_GCD_STEP: begin
				if (gcd_done) begin
					g_q <= (gx_q | gy_q) << gk_q;
				end else if (!gx_q[0] && !gy_q[0]) begin
					gx_q <= gx_q >> 1;
					gy_q <= gy_q >> 1;
					gk_q <= gk_q + 6'd1;
				end else if (!gx_q[0]) begin
					gx_q <= gx_q >> 1;
				end else if (!gy_q[0]) begin
					gy_q <= gy_q >> 1;
				end else if (gx_q >= gy_q) begin
					gx_q <= gx_q - gy_q;
				end else begin
					gy_q <= gy_q - gx_q;
				end
			end
			default: ;
		endcase
	end

	// restoring divider by g, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd)
				CMD_DIV_N, CMD_DIV_D, CMD_DIV_BD, CMD_DIV_AD: cnt_q <= 7'(XW);
				CMD_DIV_STEP: if (cnt_q != '0) cnt_q <= cnt_q - 7'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_DIV_N:  begin rem_q <= '0; quo_q <= wn_q;          end
			CMD_DIV_D:  begin rem_q <= '0; quo_q <= wd_q;          end
			CMD_DIV_BD: begin rem_q <= '0; quo_q <= XW'(bd_m_q);   end
			CMD_DIV_AD: begin rem_q <= '0; quo_q <= XW'(ad_m_q);   end
			CMD_DIV_STEP: begin
				if (cnt_q != '0) begin
					if (div_ge) begin
						rem_q <= XW'(div_sh - {1'b0, g_q});
						quo_q <= {quo_q[XW-2:0], 1'b1};
					end else begin
						rem_q <= div_sh[XW-1:0];
						quo_q <= {quo_q[XW-2:0], 1'b0};
					end
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_RES_WORK: begin
				lt_q <= 1'b0;
				eq_q <= 1'b0;
				gt_q <= 1'b0;
				if (ovf) begin
					res_num_q <= '0;
					res_den_q <= '0;
					st_q      <= ST_OVF;
				end else begin
					res_num_q <= ws_q ? -$signed(wn_lo) : $signed(wn_lo);
					res_den_q <= wd_q[30:0];
					st_q      <= ST_OK;
				end
			end
			CMD_RES_ZERO, CMD_RES_ERR: begin
				res_num_q <= '0;
				res_den_q <= '0;
				lt_q      <= 1'b0;
				eq_q      <= 1'b0;
				gt_q      <= 1'b0;
				st_q      <= (cmd == CMD_RES_ERR) ? ST_ZERO : ST_OK;
			end
			CMD_RES_CMP: begin
				res_num_q <= '0;
				res_den_q <= '0;
				lt_q      <= (wn_q != '0) && ws_q;
				eq_q      <= (wn_q == '0);
				gt_q      <= (wn_q != '0) && !ws_q;
				st_q      <= ST_OK;
			end
			default: ;
		endcase
	end

	assign res_num    = res_num_q;
	assign res_den    = res_den_q;
	assign is_less    = lt_q;
	assign is_equal   = eq_q;
	assign is_greater = gt_q;
	assign status     = st_q;

endmodule

// File: src/rational_number_alu.sv
// ----------------------------------------------------------------------------
// rational_number_alu: gcd-normalized rational arithmetic unit
// Normalize, add, subtract, multiply, divide or compare two fractions with
// reduced, sign-normalized results and error status.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+--------------------------------------
//   request  | in_valid / in_ready     | operation, a_num, a_den, b_num, b_den
//   result   | out_valid / out_ready   | res_num, res_den, is_less, is_equal,
//            |                         | is_greater, status
//
// One request at a time; the binary gcd engine (one step per cycle, up to four
// runs) and the 64-step restoring divider (up to eight runs) set how long a
// request takes. Denominator errors and unused codes go straight to the result.
// A new request is taken while the previous result waits in the output reg.
// Reset clears the controller and the result valid; no clearing pass.
// ----------------------------------------------------------------------------
module rational_number_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         operation,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] res_num,
	output logic [30:0]        res_den,
	output logic               is_less,
	output logic               is_equal,
	output logic               is_greater,
	output logic [1:0]         status
);
	import rna_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rna_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rna_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.operation  (operation),
		.a_num      (a_num),
		.a_den      (a_den),
		.b_num      (b_num),
		.b_den      (b_den),
		.res_num    (res_num),
		.res_den    (res_den),
		.is_less    (is_less),
		.is_equal   (is_equal),
		.is_greater (is_greater),
		.status     (status)
	);

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_flags_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({is_less, is_equal, is_greater}))
		else $error("more than one compare flag");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> res_num == '0 && res_den == '0)
		else $error("error result carries a value");

	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK && res_num != '0 |-> res_den != '0)
		else $error("nonzero result with zero denominator");

endmodule

// File: verif/rna_checker.sv
// ----------------------------------------------------------------------------
// rna_checker: result checker for the rational number ALU
// Watches the request and result channels. Works out the reduced fraction or
// compare flags for every accepted request, queues them in order and checks
// every accepted result against the oldest entry.
// ----------------------------------------------------------------------------
module rna_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         operation,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] res_num,
	input  logic [30:0]        res_den,
	input  logic               is_less,
	input  logic               is_equal,
	input  logic               is_greater,
	input  logic [1:0]         status,
	output int                 fail_count,
	output int                 pending
);
	import rna_pkg::*;

	typedef struct packed {
		logic [31:0] num;
		logic [30:0] den;
		logic        lt;
		logic        eq;
		logic        gt;
		logic [1:0]  st;
	} rna_result_t;

	rna_result_t result_q[$];

	function automatic longint sext(input logic [31:0] v);
		logic signed [WORD_BITS-1:0] t;
		t = v[WORD_BITS-1:0];
		return longint'(t);
	endfunction

	function automatic longint unsigned mag(input longint x);
		return x < 0 ? 64'd0 - 64'(x) : 64'(x);
	endfunction

	function automatic longint unsigned gcd64(input longint unsigned a, input longint unsigned b);
		longint unsigned t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic void reduce_frac(input longint n, input longint d,
			output longint rn, output longint rd);
		longint unsigned g;
		g = gcd64(mag(n), mag(d));
		if (g == 0)
			g = 1;
		rn = n / longint'(g);
		rd = d / longint'(g);
		if (rd < 0) begin
			rn = -rn;
			rd = -rd;
		end
	endfunction

	function automatic void lcm_sum(input longint an, input longint ad, input longint bn,
			input longint bd, input logic sub, output longint rn, output longint rd);
		longint unsigned g;
		longint fa, fb, ta, tb;
		g = gcd64(64'(ad), 64'(bd));
		fa = longint'(64'(bd) / g);
		fb = longint'(64'(ad) / g);
		ta = an * fa;
		tb = bn * fb;
		reduce_frac(sub ? ta - tb : ta + tb, ad * fa, rn, rd);
	endfunction

	function automatic rna_result_t predict_fraction(input logic [2:0] op,
			input logic [31:0] an_w, input logic [31:0] ad_w,
			input logic [31:0] bn_w, input logic [31:0] bd_w);
		rna_result_t r;
		longint an, ad, bn, bd, rn, rd, lim;
		r = '0;
		an = sext(an_w);
		ad = sext(ad_w);
		bn = sext(bn_w);
		bd = sext(bd_w);
		lim = longint'(LIM);
		if (op > OP_CMP)
			return r;
		if (ad == 0 || (op != OP_NORM && bd == 0)) begin
			r.st = ST_ZERO;
			return r;
		end
		reduce_frac(an, ad, an, ad);
		if (op != OP_NORM)
			reduce_frac(bn, bd, bn, bd);
		case (op)
			OP_NORM: begin
				rn = an;
				rd = ad;
			end
			OP_ADD: lcm_sum(an, ad, bn, bd, 1'b0, rn, rd);
			OP_SUB: lcm_sum(an, ad, bn, bd, 1'b1, rn, rd);
			OP_MUL: reduce_frac(an * bn, ad * bd, rn, rd);
			OP_DIV: begin
				if (bn == 0) begin
					r.st = ST_ZERO;
					return r;
				end
				reduce_frac(an * bd, ad * bn, rn, rd);
			end
			default: begin
				lcm_sum(an, ad, bn, bd, 1'b1, rn, rd);
				r.lt = rn < 0;
				r.eq = rn == 0;
				r.gt = rn > 0;
				return r;
			end
		endcase
		if (rn < -lim || rn > lim - 1 || rd > lim - 1) begin
			r.st = ST_OVF;
			return r;
		end
		r.num = rn[31:0];
		r.den = rd[30:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rna_result_t exp_r, got;
		if (!arst_n) begin
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (in_valid && in_ready)
				result_q.push_back(predict_fraction(operation, a_num, a_den, b_num, b_den));
			if (out_valid && out_ready) begin
				got = {res_num, res_den, is_less, is_equal, is_greater, status};
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = result_q.pop_front();
					if (got !== exp_r) begin
						$display("%0t: expected num %0d den %0d lt %b eq %b gt %b st %0d",
							$time, $signed(exp_r.num), exp_r.den, exp_r.lt, exp_r.eq,
							exp_r.gt, exp_r.st);
						$display("%0t: actual   num %0d den %0d lt %b eq %b gt %b st %0d",
							$time, res_num, res_den, is_less, is_equal, is_greater, status);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= result_q.size();
		end
	end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the rational number ALU
// Directed requests for extremes, errors, overflow and every operation, then
// random requests under varying sender and receiver idling, with a long
// result stall and a full drain. Checking is done by rna_checker.
// ----------------------------------------------------------------------------
module testbench;
	import rna_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         operation;
	logic signed [31:0] a_num, a_den, b_num, b_den;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] res_num;
	logic [30:0]        res_den;
	logic               is_less, is_equal, is_greater;
	logic [1:0]         status;
	int                 fail_count;
	int                 pending;
	int                 send_idle, recv_idle;
	logic               hold_results;

	localparam logic signed [31:0] MAXW = 32'sh7fffffff;
	localparam logic signed [31:0] MINW = 32'sh80000000;

	rational_number_alu u_top (.*);

	rna_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#100000000;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		int cnt;
		if (!arst_n) begin
			out_ready <= 1'b0;
			cnt = 0;
		end else if (hold_results && cnt < 3000) begin
			out_ready <= 1'b0;
			cnt++;
		end else begin
			out_ready <= $urandom_range(99) >= recv_idle;
		end
	end

	task automatic send_request(input logic [2:0] op, input logic [31:0] an,
			input logic [31:0] ad, input logic [31:0] bn, input logic [31:0] bd);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		a_num     <= an;
		a_den     <= ad;
		b_num     <= bn;
		b_den     <= bd;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [31:0] rand_word(input logic den);
		case ($urandom_range(9))
			0, 1:    return $urandom;
			2:       return $urandom_range(1) ? MAXW : MINW;
			3:       return den ? 32'd0 : -32'sd1;
			4:       return $urandom & 32'h0000ffff;
			default: return 32'($signed($urandom_range(40)) - 20);
		endcase
	endfunction

	task automatic random_requests(input int n);
		logic [31:0] ad, bd;
		repeat (n) begin
			ad = rand_word(1'b1);
			bd = rand_word(1'b1);
			if (ad == 0 && $urandom_range(3) != 0)
				ad = 1;
			if (bd == 0 && $urandom_range(3) != 0)
				bd = $urandom_range(9) + 1;
			send_request($urandom_range(9) == 0 ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5)),
				rand_word(1'b0), ad, rand_word(1'b0), bd);
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = OP_NORM;
		a_num        = '0;
		a_den        = 32'sd1;
		b_num        = '0;
		b_den        = 32'sd1;
		hold_results = 1'b0;
		send_idle    = 37;
		recv_idle    = 59;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_NORM, 32'sd6, -32'sd4, 32'sd0, 32'sd0);
		send_request(OP_NORM, MINW, -32'sd1, 32'sd3, 32'sd5);
		send_request(OP_NORM, 32'sd1, MINW, 32'sd0, 32'sd1);
		send_request(OP_NORM, MINW, MINW, 32'sd0, 32'sd1);
		send_request(OP_NORM, 32'sd0, -32'sd7, 32'sd0, 32'sd1);
		send_request(OP_NORM, 32'sd3, 32'sd0, 32'sd1, 32'sd1);
		send_request(OP_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd0);
		send_request(OP_ADD, 32'sd1, 32'sd6, 32'sd1, 32'sd4);
		send_request(OP_ADD, MAXW, 32'sd1, MAXW, 32'sd1);
		send_request(OP_ADD, MINW, MINW, MINW, MAXW);
		send_request(OP_SUB, 32'sd1, 32'sd3, 32'sd1, 32'sd2);
		send_request(OP_SUB, MINW, 32'sd1, MAXW, 32'sd1);
		send_request(OP_SUB, MINW, 32'sd1, MINW, MINW);
		send_request(OP_MUL, MAXW, 32'sd1, 32'sd2, 32'sd1);
		send_request(OP_MUL, -32'sd2, 32'sd3, 32'sd9, 32'sd4);
		send_request(OP_MUL, 32'sd1, MAXW, 32'sd1, MAXW);
		send_request(OP_DIV, 32'sd1, 32'sd2, 32'sd0, 32'sd5);
		send_request(OP_DIV, 32'sd3, 32'sd4, -32'sd9, 32'sd8);
		send_request(OP_DIV, MINW, 32'sd1, -32'sd1, 32'sd1);
		send_request(OP_CMP, 32'sd1, 32'sd2, 32'sd2, 32'sd4);
		send_request(OP_CMP, MINW, 32'sd1, MAXW, 32'sd1);
		send_request(OP_CMP, MAXW, 32'sd1, MINW, MAXW);
		send_request(3'd6, MAXW, 32'sd0, 32'sd1, 32'sd0);
		send_request(3'd7, -32'sd1, -32'sd1, -32'sd1, -32'sd1);

		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);

		hold_results <= 1'b1;
		random_requests(250);
		send_idle = 59;
		recv_idle = 37;
		random_requests(250);
		send_idle = 0;
		recv_idle = 0;
		random_requests(250);
		in_valid <= 1'b0;
		@(posedge clk);

		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
